@@ sv/bounded_list_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list engine
// Shared shorthand for the concurrent checks of the list engine.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ble_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded list engine package
// Action and status codes and the command bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActW    = 3;
  localparam int unsigned StatW   = 3;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned RdSpan  = 16;

  typedef enum logic [ActW-1:0] {
    ACT_FRONT  = 3'd0,
    ACT_BACK   = 3'd1,
    ACT_SORT   = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_READ   = 3'd4
  } act_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } stat_e;

  // Request broadcast to every cell of the chain.
  typedef struct packed {
    act_e                     op;
    logic signed [DataW-1:0]  value;
  } cmd_t;

endpackage

@@ sv/bounded_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// Bounded list engine
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one per position with the head in
// cell 0. Every request is broadcast to all cells at once; each cell decides
// whether it is a candidate edit point, and a one-bit mark ripples down the
// chain so that only the first candidate acts. On an insert the cells past
// that point take their left neighbor's entry, and on a remove the point and
// all cells past it take their right neighbor's entry. The entry count is a
// single register next to the chain. A request's result is registered at the
// edge that accepts it, and a new request is taken in every cycle as long as
// the result register is empty or being drained in that cycle. The critical
// path is the 32-bit compare in a cell followed by the mark ripple through
// the chain. Inserts into a full list are dropped with status full, removes
// of an absent value leave the list unchanged, and reads at or beyond the
// count report a bad index. The entry field is zero except for a successful
// read.
// ----------------------------------------------------------------------------
module bounded_list_engine_core
  import ble_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [IdxW-1:0]         index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [CountW-1:0]       count_o,
  output logic signed [DataW-1:0] entry_o
);

`include "bounded_list_engine_core_macros.svh"

  localparam int unsigned UsedW = $clog2(DEPTH + 1);

  // Request handshake.
  logic accept;
  logic out_valid_q;

  // Entry count and chain wiring.
  logic [UsedW-1:0]        used_q, used_d;
  cmd_t                    cmd;
  logic                    apply;
  logic [DEPTH:0]          mark;
  logic [DEPTH-1:0]        live;
  logic signed [DataW-1:0] cell_e [DEPTH];
  logic signed [DataW-1:0] rd_tab [RdSpan];
  logic                    found;
  logic                    full;

  // Result registers.
  stat_e                   status_d, status_q;
  logic [CountW-1:0]       count_q;
  logic signed [DataW-1:0] entry_d, entry_q;
  logic [UsedW+CountW-1:0] used_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd.op    = act_e'(action_i);
  assign cmd.value = value_i;
  assign mark[0]   = 1'b0;
  assign found     = mark[DEPTH];
  assign full      = (used_q == UsedW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_e;
    logic signed [DataW-1:0] right_e;

    assign live[i] = (UsedW'(i) < used_q);

    if (i == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_body
      assign left_e = cell_e[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cell_e[i+1];
    end

    ble_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .apply_i   (apply),
      .head_i    (i == 0),
      .live_i    (live[i]),
      .left_e_i  (left_e),
      .right_e_i (right_e),
      .mark_i    (mark[i]),
      .mark_o    (mark[i+1]),
      .e_o       (cell_e[i])
    );
  end

  // Only the first positions can be addressed by the index field.
  for (genvar k = 0; k < RdSpan; k++) begin : g_rd
    if (k < DEPTH) begin : g_on
      assign rd_tab[k] = cell_e[k];
    end else begin : g_off
      assign rd_tab[k] = '0;
    end
  end

  // Status, count update and the commit strobe for the cells.
  always_comb begin
    status_d = ST_OK;
    entry_d  = '0;
    used_d   = used_q;
    apply    = 1'b0;
    case (cmd.op)
      ACT_FRONT, ACT_BACK, ACT_SORT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          apply  = accept;
          used_d = used_q + UsedW'(1);
        end
      end
      ACT_REMOVE: begin
        if (used_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          apply  = accept;
          used_d = used_q - UsedW'(1);
        end
      end
      ACT_READ: begin
        if ((UsedW+IdxW)'(index_i) >= (UsedW+IdxW)'(used_q)) begin
          status_d = ST_BAD_INDEX;
        end else begin
          entry_d = rd_tab[index_i];
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // The count field carries the low bits of the new entry count.
  assign used_ext = (UsedW+CountW)'(used_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        used_q <= used_d;
      end
      out_valid_q <= accept || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      count_q  <= used_ext[CountW-1:0];
      entry_q  <= entry_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = count_q;
  assign entry_o     = entry_q;

  // The count never exceeds the number of cells.
  `BLE_ASSERT_IMP(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= UsedW'(DEPTH), "count above depth")

  // A dropped insert into a full list leaves the list full.
  `BLE_ASSERT_NXT(a_full_hold, clk_i, rst_ni, accept && full && (action_i == ACT_FRONT || action_i == ACT_BACK || action_i == ACT_SORT), used_q == UsedW'(DEPTH), "full insert changed count")

  // A successful remove shrinks the list by exactly one entry.
  `BLE_ASSERT_NXT(a_remove_dec, clk_i, rst_ni, accept && found && (action_i == ACT_REMOVE), used_q == $past(used_q) - UsedW'(1), "remove miscounted")

  // A nonzero entry is only reported by a successful read.
  `BLE_ASSERT_IMP(a_entry_read, clk_i, rst_ni, out_valid_q && (entry_q != '0), status_q == ST_OK, "entry on failed request")

endmodule

@@ sv/ble_cell.sv @@
// ----------------------------------------------------------------------------
// Bounded list engine cell
// One list position: holds an entry, finds the edit point and shifts.
// ----------------------------------------------------------------------------
module ble_cell
  import ble_pkg::*;
(
  input  logic                    clk_i,
  input  cmd_t                    cmd_i,
  input  logic                    apply_i,
  input  logic                    head_i,
  input  logic                    live_i,
  input  logic signed [DataW-1:0] left_e_i,
  input  logic signed [DataW-1:0] right_e_i,
  input  logic                    mark_i,
  output logic                    mark_o,
  output logic signed [DataW-1:0] e_o
);

  logic signed [DataW-1:0] e_q, e_d;
  logic                    hit;

  // A hit marks a candidate edit position; the first hit in the chain wins.
  always_comb begin
    case (cmd_i.op)
      ACT_FRONT:  hit = 1'b1;
      ACT_BACK:   hit = !live_i;
      ACT_SORT:   hit = head_i ? (!live_i || (cmd_i.value < e_q))
                               : (!live_i || !(e_q < cmd_i.value));
      ACT_REMOVE: hit = live_i && (e_q == cmd_i.value);
      default:    hit = 1'b0;
    endcase
  end

  assign mark_o = mark_i | hit;

  always_comb begin
    e_d = e_q;
    if (apply_i) begin
      case (cmd_i.op)
        ACT_FRONT, ACT_BACK, ACT_SORT: begin
          if (mark_i) begin
            e_d = left_e_i;
          end else if (hit) begin
            e_d = cmd_i.value;
          end
        end
        ACT_REMOVE: begin
          if (mark_o) begin
            e_d = right_e_i;
          end
        end
        default: e_d = e_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
  end

  assign e_o = e_q;

endmodule

@@ dv/ble_list_checker.sv @@
// ----------------------------------------------------------------------------
// Bounded list engine result checker
// Watches both channels, keeps a shadow copy of the list, and compares every
// result with the result that the shadow list predicts for its request.
// ----------------------------------------------------------------------------
module ble_list_checker
  import ble_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [IdxW-1:0]         index_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [StatW-1:0]        status_i,
  input  logic [CountW-1:0]       count_i,
  input  logic signed [DataW-1:0] entry_i,
  output int unsigned             mismatches_o,
  output int unsigned             compared_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic [CountW-1:0]       count;
    logic signed [DataW-1:0] entry;
  } list_result_t;

  logic signed [DataW-1:0] shadow_list [DEPTH];
  int unsigned             shadow_used;
  list_result_t            awaited_results [$];

  // Applies one request to the shadow list and returns the result it gives.
  function automatic list_result_t apply_request(input logic [ActW-1:0] act,
                                                 input logic signed [DataW-1:0] val,
                                                 input logic [IdxW-1:0] idx);
    list_result_t res;
    int unsigned  pos;
    res.status = ST_OK;
    res.entry  = '0;
    case (act)
      ACT_FRONT, ACT_BACK, ACT_SORT: begin
        if (shadow_used >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (act == ACT_FRONT) begin
            pos = 0;
          end else if (act == ACT_BACK) begin
            pos = shadow_used;
          end else if (shadow_used == 0 || val < shadow_list[0]) begin
            pos = 0;
          end else begin
            // The head is passed over even when it equals the new value.
            pos = 1;
            while (pos < shadow_used && shadow_list[pos] < val) pos++;
          end
          for (int unsigned i = shadow_used; i > pos; i--) begin
            shadow_list[i] = shadow_list[i-1];
          end
          shadow_list[pos] = val;
          shadow_used++;
        end
      end
      ACT_REMOVE: begin
        if (shadow_used == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_used && shadow_list[pos] != val) pos++;
          if (pos >= shadow_used) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (int unsigned i = pos; i + 1 < shadow_used; i++) begin
              shadow_list[i] = shadow_list[i+1];
            end
            shadow_used--;
          end
        end
      end
      ACT_READ: begin
        if (idx >= shadow_used) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.entry = shadow_list[idx];
        end
      end
      default: ;
    endcase
    res.count = CountW'(shadow_used);
    return res;
  endfunction

  task automatic log_mismatch(input string field, input logic [DataW-1:0] want,
                              input logic [DataW-1:0] got);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("result %0d: %s expected 0x%0h, got 0x%0h", compared_o, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_used = 0;
      awaited_results.delete();
      mismatches_o = 0;
      compared_o   = 0;
      pending_o   <= 0;
    end else begin
      // A request is queued before the result of the same edge is taken, so
      // the oldest expectation is always the one at the front.
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_request(action_i, value_i, index_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("result %0d arrived with no request pending (status %0d)",
                     compared_o, status_i);
          end
        end else begin
          want = awaited_results.pop_front();
          if (status_i !== want.status) log_mismatch("status", want.status, status_i);
          if (count_i !== want.count) log_mismatch("count", want.count, count_i);
          if (entry_i !== want.entry) log_mismatch("entry", want.entry, entry_i);
        end
        compared_o++;
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Bounded list engine testbench
// Drives list requests into the engine under random back pressure and lets
// the result checker compare every result against a shadow list.
// ----------------------------------------------------------------------------
module tb;
  import ble_pkg::*;

  localparam int unsigned Depth      = 16;
  // Number of list requests (inserts, removes and reads) in the whole run, less 30.
  localparam int unsigned ItemTarget = 650;
  // The last requests run with neither side idling.
  localparam int unsigned QuietTail  = 80;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Action codes that the engine accepts but ignores.
  localparam logic [ActW-1:0] ActSpareLo  = 3'd5;
  localparam logic [ActW-1:0] ActSpareMid = 3'd6;
  localparam logic [ActW-1:0] ActSpareHi  = 3'd7;

  typedef enum int unsigned {
    MIX_GROW,
    MIX_SHRINK,
    MIX_SORTED,
    MIX_BLEND
  } mix_e;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [ActW-1:0]         action_i    = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic [IdxW-1:0]         index_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [StatW-1:0]        status_o;
  logic [CountW-1:0]       count_o;
  logic signed [DataW-1:0] entry_o;

  int unsigned mismatches;
  int unsigned compared;
  int unsigned pending;

  // Set for the tail of the run, where neither side may idle.
  bit          calm_tail = 1'b0;
  int unsigned inserts_sent = 0;
  int unsigned removes_sent = 0;
  int unsigned reads_sent   = 0;
  int unsigned spares_sent  = 0;

  always #1 clk_i = ~clk_i;

  bounded_list_engine_core #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .count_o    (count_o),
    .entry_o    (entry_o)
  );

  ble_list_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status_o),
    .count_i     (count_o),
    .entry_i     (entry_o),
    .mismatches_o(mismatches),
    .compared_o  (compared),
    .pending_o   (pending)
  );

  // Presents one request and returns at the edge where it is accepted. It is
  // always called right after a rising edge. Valid is left high on return, so
  // a request that follows at once keeps valid up without a dip.
  task automatic send_request(input logic [ActW-1:0] act,
                              input logic signed [DataW-1:0] val,
                              input logic [IdxW-1:0] idx);
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    index_i    <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    case (act)
      ACT_FRONT, ACT_BACK, ACT_SORT: inserts_sent++;
      ACT_REMOVE:                    removes_sent++;
      ACT_READ:                      reads_sent++;
      default:                       spares_sent++;
    endcase
  endtask

  // Drops valid and waits for every outstanding result to come back. The
  // pending count is updated at the edge, so the loop sees the value from before it.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // The result side drops ready in random bursts. Stalling itself is
  // switched on and off at random so that long stretches run without it.
  initial begin : result_sink
    bit          stalls_on;
    int unsigned gap;
    stalls_on = 1'b1;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) stalls_on = !stalls_on;
      if (!calm_tail && stalls_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Any cycle with a handshake on either channel counts as progress. A run
  // that goes StallLimit cycles without one has lost a request or a result.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("no handshake for %0d cycles, %0d results still pending", StallLimit, pending);
    $display("[bounded_list_engine_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    mix_e                    mix;
    int unsigned             phase_left;
    int unsigned             pick;
    int unsigned             t_front, t_back, t_sort, t_remove, t_read;
    bit                      gaps_on;
    bit                      midway_drained;
    logic [ActW-1:0]         act;
    logic signed [DataW-1:0] val;

    phase_left     = 0;
    gaps_on        = 1'b0;
    midway_drained = 1'b0;
    mix            = MIX_BLEND;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The empty list first: a read and a remove both fail.
    send_request(ACT_READ, '0, '0);
    send_request(ACT_REMOVE, 32'sd5, '0);
    // The spare action codes change nothing and report ok.
    send_request(ActSpareLo, 32'h7FFF_FFFF, 4'hF);
    send_request(ActSpareMid, 32'h8000_0000, 4'h0);
    send_request(ActSpareHi, '1, 4'hA);
    // Sorted insert into an empty list, below the head, equal to the head
    // and above everything, then plain front and back inserts.
    send_request(ACT_SORT, 32'sd0, '0);
    send_request(ACT_SORT, 32'h8000_0000, '0);
    send_request(ACT_SORT, 32'h8000_0000, '0);
    send_request(ACT_SORT, 32'h7FFF_FFFF, '0);
    send_request(ACT_FRONT, 32'h5555_5555, '0);
    send_request(ACT_BACK, 32'hAAAA_AAAA, '0);
    // Remove of an absent value, then of the largest value.
    send_request(ACT_REMOVE, 32'sd123, '0);
    send_request(ACT_REMOVE, 32'h7FFF_FFFF, '0);
    // Read past the count, then fill the list to the brim.
    send_request(ACT_READ, '0, 4'hF);
    for (int k = 0; k < 11; k++) send_request(ACT_BACK, $urandom(), '0);
    // With the list full an insert is dropped, and the last slot is readable.
    send_request(ACT_SORT, 32'sd1, '0);
    send_request(ACT_READ, '0, 4'hF);
    send_request(ACT_READ, '0, 4'h0);
    hold_until_drained();

    // Random part, in phases that push the list toward full, toward empty,
    // keep it sorted, or stir it evenly. Small values dominate so that
    // removes find their target and sorted inserts meet equal entries.
    while (inserts_sent + removes_sent + reads_sent < ItemTarget + 30) begin
      if (phase_left == 0) begin
        mix        = mix_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 60);
        gaps_on    = ($urandom_range(0, 2) != 0);
        case (mix)
          MIX_GROW:   begin t_front = 25; t_back = 50; t_sort = 75; t_remove = 85; t_read = 97; end
          MIX_SHRINK: begin t_front = 8;  t_back = 16; t_sort = 24; t_remove = 70; t_read = 95; end
          MIX_SORTED: begin t_front = 0;  t_back = 0;  t_sort = 60; t_remove = 75; t_read = 97; end
          default:    begin t_front = 15; t_back = 30; t_sort = 50; t_remove = 72; t_read = 96; end
        endcase
      end
      phase_left--;
      if (inserts_sent + removes_sent + reads_sent >= ItemTarget + 30 - QuietTail) begin
        calm_tail = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < t_front)       act = ACT_FRONT;
      else if (pick < t_back)   act = ACT_BACK;
      else if (pick < t_sort)   act = ACT_SORT;
      else if (pick < t_remove) act = ACT_REMOVE;
      else if (pick < t_read)   act = ACT_READ;
      else                      act = ActW'($urandom_range(ActSpareLo, ActSpareHi));

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: val = 32'($urandom_range(0, 16)) - 32'd8;
        5: begin
          case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = '0;
            default: val = '1;
          endcase
        end
        default: val = $urandom();
      endcase

      send_request(act, val, IdxW'($urandom_range(0, 15)));

      // Once around the middle the sender waits for every outstanding result to come back.
      if (!midway_drained && inserts_sent + removes_sent + reads_sent >= ItemTarget / 2) begin
        midway_drained = 1'b1;
        hold_until_drained();
      end else if (!calm_tail && gaps_on && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end

    hold_until_drained();
    // The result of a request is registered at its accepting edge; the spare
    // cycles below catch any stray result.
    repeat (8) @(posedge clk_i);

    $display("Covered %0d inserts, %0d removes, %0d reads and %0d spare-code requests;",
             inserts_sent, removes_sent, reads_sent, spares_sent);
    $display("%0d results compared against the shadow list, %0d mismatches.",
             compared, mismatches);
    if (mismatches == 0) begin
      $display("[bounded_list_engine_core] OK");
    end else begin
      $display("[bounded_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/ble_pkg.sv
sv/ble_cell.sv
sv/bounded_list_engine_core.sv
dv/ble_list_checker.sv
dv/tb.sv
